[design/cfkp_pkg.sv]
// Types and constants shared by the command frame keyword parser modules.
`timescale 1ns / 1ps
`default_nettype none

package cfkp_pkg;

  localparam int unsigned FieldStart = 5;
  localparam int unsigned NameSlots  = 7;
  localparam int unsigned NameCount  = 6;
  localparam int unsigned SepMinPos  = FieldStart + 5;

  localparam logic [47:0] SEP_PATTERN = 48'h3B_54_45_58_54_3A; // ";TEXT:"
  localparam logic [3:0]  NAME_LONG   = 4'd15;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_FORWARD = 3'd1,
    ACT_BACK    = 3'd2,
    ACT_LEFT    = 3'd3,
    ACT_RIGHT   = 3'd4,
    ACT_STOP    = 3'd5
  } action_code_t;

  typedef logic [NameSlots-1:0][7:0] name_bytes_t;

  // Frame status as it stands once the current byte has been taken in.
  typedef struct packed {
    logic       length_ok;      // at least five bytes and not too long
    logic       prefix_good;
    logic       separator_seen;
    logic [3:0] field_len;
  } frame_status_t;

  localparam name_bytes_t WORD_TABLE [NameCount] = '{
    {8'h00, 8'h00, 8'h00, "E", "N", "O", "N"},
    {"D",   "R",   "A",   "W", "R", "O", "F"},
    {8'h00, 8'h00, 8'h00, "K", "C", "A", "B"},
    {8'h00, 8'h00, 8'h00, "T", "F", "E", "L"},
    {8'h00, 8'h00, "T",   "H", "G", "I", "R"},
    {8'h00, 8'h00, 8'h00, "P", "O", "T", "S"}
  };

  localparam logic [3:0] WORD_LEN [NameCount] = '{4'd4, 4'd7, 4'd4, 4'd4, 4'd5, 4'd4};

  // Expected byte of the "@CMD:" lead-in at a given offset.
  function automatic logic [7:0] lead_byte(input logic [2:0] pos);
    logic [7:0] b;
    case (pos)
      3'd0:    b = "@";
      3'd1:    b = "C";
      3'd2:    b = "M";
      3'd3:    b = "D";
      3'd4:    b = ":";
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

[design/cfkp_frame_track.sv]
// Per-frame state: byte counter, lead-in check, separator window and action field store.
`timescale 1ns / 1ps
`default_nettype none

module cfkp_frame_track
  import cfkp_pkg::*;
#(
  parameter int unsigned MAX_LINE = 128
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          step,
  input  wire logic [7:0]    frame_byte,
  input  wire logic          frame_end,
  output frame_status_t      status,
  output name_bytes_t        name_store
);

  logic [7:0]  byte_count_r, byte_count_nxt;
  logic        prefix_good_r, prefix_good_nxt;
  logic [47:0] recent_bytes_r, recent_bytes_nxt;
  logic        separator_seen_r, separator_seen_nxt;
  logic [3:0]  field_len_r, field_len_nxt;
  name_bytes_t name_store_r;

  logic        sep_hit;
  logic [7:0]  len_calc;
  logic        store_we;
  logic [2:0]  store_off;

  always_comb begin
    prefix_good_nxt = prefix_good_r;
    if (byte_count_r < 8'(FieldStart) && frame_byte != lead_byte(byte_count_r[2:0])) begin
      prefix_good_nxt = 1'b0;
    end

    recent_bytes_nxt = {recent_bytes_r[39:0], frame_byte};
    sep_hit  = !separator_seen_r && byte_count_r >= 8'(SepMinPos) &&
               recent_bytes_nxt == SEP_PATTERN;
    len_calc = byte_count_r - 8'(SepMinPos);

    field_len_nxt = field_len_r;
    if (sep_hit) begin
      field_len_nxt = (len_calc <= 8'(NameSlots)) ? len_calc[3:0] : NAME_LONG;
    end
    separator_seen_nxt = separator_seen_r | sep_hit;

    byte_count_nxt = (byte_count_r == 8'hFF) ? byte_count_r : byte_count_r + 8'd1;

    store_we  = !separator_seen_r && byte_count_r >= 8'(FieldStart) &&
                byte_count_r < 8'(FieldStart + NameSlots);
    store_off = 3'(byte_count_r - 8'(FieldStart));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r     <= '0;
      prefix_good_r    <= 1'b1;
      recent_bytes_r   <= '0;
      separator_seen_r <= 1'b0;
      field_len_r      <= '0;
    end else if (step) begin
      if (frame_end) begin
        byte_count_r     <= '0;
        prefix_good_r    <= 1'b1;
        recent_bytes_r   <= '0;
        separator_seen_r <= 1'b0;
        field_len_r      <= '0;
      end else begin
        byte_count_r     <= byte_count_nxt;
        prefix_good_r    <= prefix_good_nxt;
        recent_bytes_r   <= recent_bytes_nxt;
        separator_seen_r <= separator_seen_nxt;
        field_len_r      <= field_len_nxt;
      end
    end
  end

  // The store is never cleared: only entries written by the current frame are compared.
  always_ff @(posedge clk) begin
    if (step && store_we) begin
      name_store_r[store_off] <= frame_byte;
    end
  end

  // Entries compared at the final byte all lie before the current byte, so the
  // registered store is already complete.
  always_comb begin
    status.length_ok      = byte_count_r < 8'(MAX_LINE) && byte_count_r >= 8'(FieldStart - 1);
    status.prefix_good    = prefix_good_nxt;
    status.separator_seen = separator_seen_nxt;
    status.field_len      = field_len_nxt;
  end

  assign name_store = name_store_r;

endmodule

`default_nettype wire

[design/cfkp_word_match.sv]
// Compares the stored action field against the six action names.
`timescale 1ns / 1ps
`default_nettype none

module cfkp_word_match
  import cfkp_pkg::*;
(
  input  wire name_bytes_t name_store,
  input  wire logic [3:0]  field_len,
  output logic             hit,
  output action_code_t     code
);

  logic [NameCount-1:0] word_hit;

  always_comb begin
    for (int w = 0; w < NameCount; w++) begin
      word_hit[w] = (field_len == WORD_LEN[w]);
      for (int k = 0; k < NameSlots; k++) begin
        if (4'(k) < WORD_LEN[w] && name_store[k] != WORD_TABLE[w][k]) begin
          word_hit[w] = 1'b0;
        end
      end
    end
  end

  // Name spellings differ, so at most one name can match.
  always_comb begin
    hit  = |word_hit;
    code = ACT_NONE;
    if      (word_hit[1]) code = ACT_FORWARD;
    else if (word_hit[2]) code = ACT_BACK;
    else if (word_hit[3]) code = ACT_LEFT;
    else if (word_hit[4]) code = ACT_RIGHT;
    else if (word_hit[5]) code = ACT_STOP;
  end

endmodule

`default_nettype wire

[design/command_frame_keyword_parser_unit.sv]
// Top level of the command frame keyword parser: input stage, result register and handshakes.
// The parser takes one frame byte per cycle on the in_ stream, with in_tlast on the final
// byte, and raises out_tvalid with one result per frame once that final byte's result is
// registered: bit 0 of out_tdata says whether the frame was well formed ("@CMD:" lead-in,
// 5 to MAX_LINE bytes, ";TEXT:" separator) with a known action name, bits 3:1 give the
// action code. Each byte passes from an input register through the lead-in, separator-window
// and name compare logic into the result register, so a byte can be taken in every cycle;
// the only stall is a final byte that meets a result still waiting to be taken on the out_ side.
`timescale 1ns / 1ps
`default_nettype none

module command_frame_keyword_parser_unit
  import cfkp_pkg::*;
#(
  parameter int unsigned MAX_LINE = 128
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] frame_byte
  input  wire logic       in_tlast,   // frame_end
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata   // [0] accepted, [3:1] action_code, [7:4] zero
);

  logic          s1_valid_r;
  logic [7:0]    s1_byte_r;
  logic          s1_end_r;
  logic          s1_go;
  logic          out_free;

  logic          out_valid_r;
  logic          accepted_r, accepted_nxt;
  action_code_t  code_r, code_nxt;

  frame_status_t status;
  name_bytes_t   name_store;
  logic          word_hit;
  action_code_t  word_code;

  assign out_free  = !out_valid_r || out_tready;
  assign s1_go     = s1_valid_r && (!s1_end_r || out_free);
  assign in_tready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
      s1_end_r  <= in_tlast;
    end
  end

  cfkp_frame_track #(
    .MAX_LINE (MAX_LINE)
  ) u_track (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (s1_go),
    .frame_byte (s1_byte_r),
    .frame_end  (s1_end_r),
    .status     (status),
    .name_store (name_store)
  );

  cfkp_word_match u_match (
    .name_store (name_store),
    .field_len  (status.field_len),
    .hit        (word_hit),
    .code       (word_code)
  );

  always_comb begin
    accepted_nxt = status.length_ok && status.prefix_good && status.separator_seen &&
                   word_hit;
    code_nxt     = accepted_nxt ? word_code : ACT_NONE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_end_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_end_r) begin
      accepted_r <= accepted_nxt;
      code_r     <= code_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, code_r, accepted_r};

  // A rejected frame always reports the NONE code.
  a_reject_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[3:1] == ACT_NONE)
    else $error("rejected frame carries a non-zero action code");

  // Codes above STOP are never produced.
  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[3:1] <= ACT_STOP)
    else $error("action code out of range");

  // Only a final byte can hold up the input stage.
  a_no_stall_mid_frame: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_end_r |-> in_tready)
    else $error("input stalled on a byte that is not the last of its frame");

  // A new result only follows a final byte leaving the input stage.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    !(s1_valid_r && s1_end_r) |=> !$rose(out_valid_r))
    else $error("result raised without a final byte");

endmodule

`default_nettype wire
